// ===== sv/cdad_pkg.sv =====
package cdad_pkg;

    // upper bound of the year walk
    localparam int MAX_YEAR = 9999;

    // internal year width, never narrower than the 14-bit year fields
    localparam int YEAR_W = ($clog2(MAX_YEAR + 1) > 14) ? $clog2(MAX_YEAR + 1) : 14;

    // leap-year cycle lengths
    localparam int YEAR_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int LEAP_STEP  = 4;

    // month lengths
    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [4:0] DAYS_FEB      = 5'd28;
    localparam logic [4:0] DAYS_SHORT    = 5'd30;
    localparam logic [4:0] DAYS_LONG     = 5'd31;

    // month codes
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef logic [YEAR_W-1:0] year_t;
    typedef logic [8:0]        cyc_pos_t;

    // leap test from the position of the year within the 400-year cycle
    function automatic logic cdad_is_leap(input cyc_pos_t pos);
        logic by_four;
        by_four = ((pos % LEAP_STEP) == 0);
        cdad_is_leap = (pos == 9'd0) ||
                       (by_four && (pos != 9'(CENTURY)) && (pos != 9'(2 * CENTURY)) &&
                        (pos != 9'(3 * CENTURY)));
    endfunction

    function automatic logic [4:0] cdad_month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            MON_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_SHORT;
            default: len = DAYS_LONG;
        endcase
        cdad_month_len = len;
    endfunction

endpackage

// ===== sv/calendar_date_add_days_core.sv =====
// from accept to out_valid a word passes the states reduce, clamp, walk and done, in that order
// the day walk advances one day per cycle, the year reduction subtracts 400 per cycle
// a new word is taken only in idle, so the block takes no new word until the last one has left done
// the result sits in an output register, so a new word is taken while a result waits
// reset (rst_n, async, active low) clears the sequencer and out_valid; data regs are not reset
module calendar_date_add_days_core
    import cdad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [13:0]        start_year,
    input  logic [3:0]         start_month,
    input  logic [4:0]         start_day,
    input  logic signed [15:0] day_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [13:0]        result_year,
    output logic [3:0]         result_month,
    output logic [4:0]         result_day,
    output logic               range_error
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a word
    localparam logic [2:0] ST_REDUCE = 3'd1;  // year mod 400 by repeated subtraction
    localparam logic [2:0] ST_CLAMP  = 3'd2;  // clip day to the month length
    localparam logic [2:0] ST_WALK   = 3'd3;  // one day per cycle
    localparam logic [2:0] ST_DONE   = 3'd4;  // hand result to the output register

    localparam year_t    YEAR_MAX   = YEAR_W'(MAX_YEAR);
    localparam year_t    YEAR_ONE   = YEAR_W'(1);
    localparam year_t    YEAR_CYC   = YEAR_W'(YEAR_CYCLE);
    localparam cyc_pos_t CYC_LAST   = 9'(YEAR_CYCLE - 1);

    logic [2:0]  state_reg, state_next;
    year_t       y_reg, y_next;
    // holds year mod 400 once the reduction is done; tracked through the walk
    year_t       rem_reg, rem_next;
    logic [3:0]  m_reg, m_next;
    logic [4:0]  d_reg, d_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        back_reg, back_next;
    logic        err_reg, err_next;

    logic        out_valid_reg, out_valid_next;
    logic [13:0] ry_reg, ry_next;
    logic [3:0]  rm_reg, rm_next;
    logic [4:0]  rd_reg, rd_next;
    logic        re_reg, re_next;

    logic        in_accept;
    logic        out_free;
    year_t       y_in;
    logic [15:0] off_mag;
    cyc_pos_t    cyc_pos;
    logic        leap_cur;
    logic [4:0]  dim_cur;
    logic [4:0]  dim_prev;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // output register can take a new result this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    assign y_in    = YEAR_W'(start_year);
    assign off_mag = day_offset[15] ? (16'd0 - unsigned'(day_offset)) : unsigned'(day_offset);

    // calendar facts for the current date
    assign cyc_pos  = rem_reg[8:0];
    assign leap_cur = cdad_is_leap(cyc_pos);
    assign dim_cur  = cdad_month_len(leap_cur, m_reg);
    assign dim_prev = cdad_month_len(leap_cur, m_reg - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        rem_next       = rem_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        back_next      = back_reg;
        err_next       = err_reg;
        ry_next        = ry_reg;
        rm_next        = rm_reg;
        rd_next        = rd_reg;
        re_next        = re_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // clip the starting year and month into range
                    if (y_in < YEAR_ONE)
                        y_next = YEAR_ONE;
                    else if (y_in > YEAR_MAX)
                        y_next = YEAR_MAX;
                    else
                        y_next = y_in;
                    rem_next = y_next;
                    if (start_month < MON_JAN)
                        m_next = MON_JAN;
                    else if (start_month > MON_DEC)
                        m_next = MON_DEC;
                    else
                        m_next = start_month;
                    d_next     = start_day;
                    cnt_next   = off_mag;
                    back_next  = day_offset[15];
                    err_next   = 1'b0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (rem_reg >= YEAR_CYC)
                    rem_next = rem_reg - YEAR_CYC;
                else
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (d_reg == 5'd0)
                    d_next = 5'd1;
                else if (d_reg > dim_cur)
                    d_next = dim_cur;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cnt_reg == 16'd0)
                    state_next = ST_DONE;
                else
                begin
                    cnt_next = cnt_reg - 16'd1;
                    if (!back_reg)
                    begin
                        priority if (d_reg < dim_cur)
                            d_next = d_reg + 5'd1;
                        else if (m_reg < MON_DEC)
                        begin
                            m_next = m_reg + 4'd1;
                            d_next = 5'd1;
                        end
                        else if (y_reg < YEAR_MAX)
                        begin
                            y_next   = y_reg + YEAR_ONE;
                            m_next   = MON_JAN;
                            d_next   = 5'd1;
                            rem_next = (cyc_pos == CYC_LAST) ? '0 :
                                       YEAR_W'(cyc_pos + 9'd1);
                        end
                        else
                        begin
                            // top of the year range: park on the last day
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        priority if (d_reg > 5'd1)
                            d_next = d_reg - 5'd1;
                        else if (m_reg > MON_JAN)
                        begin
                            m_next = m_reg - 4'd1;
                            d_next = dim_prev;
                        end
                        else if (y_reg > YEAR_ONE)
                        begin
                            y_next   = y_reg - YEAR_ONE;
                            m_next   = MON_DEC;
                            d_next   = DAYS_LONG;
                            rem_next = (cyc_pos == 9'd0) ? YEAR_W'(CYC_LAST) :
                                       YEAR_W'(cyc_pos - 9'd1);
                        end
                        else
                        begin
                            // bottom of the year range: park on 1 january of year 1
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ry_next        = y_reg[13:0];
                    rm_next        = m_reg;
                    rd_next        = d_reg;
                    re_next        = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
        back_reg <= back_next;
        err_reg  <= err_next;
        ry_reg   <= ry_next;
        rm_reg   <= rm_next;
        rd_reg   <= rd_next;
        re_reg   <= re_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_year  = ry_reg;
    assign result_month = rm_reg;
    assign result_day   = rd_reg;
    assign range_error  = re_reg;

`ifndef SYNTH
    // date stays a real calendar date while walking
    a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (d_reg >= 5'd1) && (d_reg <= dim_cur))
        else $error("day outside month during walk");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (m_reg >= MON_JAN) && (m_reg <= MON_DEC))
        else $error("month out of range during walk");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (y_reg >= YEAR_ONE) && (y_reg <= YEAR_MAX) &&
                                   (rem_reg < YEAR_CYC))
        else $error("year or cycle position out of range during walk");

    // a finished word reaches the output register once it is free
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> out_valid && (state_reg == ST_IDLE))
        else $error("result not delivered from done");
`endif

endmodule

// ===== tb/calendar_date_add_days_core_tb.sv =====
`timescale 1ns / 1ps

module calendar_date_add_days_core_tb
    import cdad_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 10000000;
    localparam int RANDOM_WORDS = 100;
    // receiver hold-off starts once this many words went in
    localparam int HOLD_AT_WORD = 45;
    localparam int HOLD_CYCLES  = 3000;
    // random word after which the sender waits for the pipe to drain
    localparam int DRAIN_AT     = 70;
    // quiet cycles after the last result, any stray word shows up here
    localparam int TAIL_CYCLES  = 100;

    // leap-rule corner years and the ends of the year range
    localparam int SPECIAL_YEARS [14] = '{1, 2, 3, 4, 100, 400, 1600, 1900,
                                          2000, 2100, 2400, 9996, 9998, 9999};

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        range_err;
    } date_t;

    // receiver stall patterns
    typedef enum int unsigned {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_RUNS
    } rx_mode_e;

    class date_scoreboard;
        date_t       pending[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function bit is_leap(int unsigned y);
            if ((y % YEAR_CYCLE) == 0)
                return 1'b1;
            if ((y % CENTURY) == 0)
                return 1'b0;
            return (y % LEAP_STEP) == 0;
        endfunction

        static function int unsigned days_in(int unsigned y, int unsigned m);
            if (m == MON_FEB)
                return is_leap(y) ? DAYS_FEB_LEAP : DAYS_FEB;
            if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
                return DAYS_SHORT;
            return DAYS_LONG;
        endfunction

        // clamp the start date, then walk it day by day until the offset is used up
        function date_t walk_date(logic [13:0] y_in, logic [3:0] m_in, logic [4:0] d_in,
                                  logic signed [15:0] offset);
            int unsigned y;
            int unsigned m;
            int unsigned d;
            int unsigned steps;
            bit          forward;
            logic        hit_edge;
            date_t       res;
            y = y_in;
            m = m_in;
            d = d_in;
            hit_edge = 1'b0;
            if (y < 1) y = 1;
            if (y > MAX_YEAR) y = MAX_YEAR;
            if (m < MON_JAN) m = MON_JAN;
            if (m > MON_DEC) m = MON_DEC;
            if (d < 1) d = 1;
            if (d > days_in(y, m)) d = days_in(y, m);
            forward = (offset >= 0);
            steps = forward ? int'(offset) : -int'(offset);
            while (steps > 0)
            begin
                if (forward)
                begin
                    if (d < days_in(y, m))
                    begin
                        d++;
                    end
                    else if (m < MON_DEC)
                    begin
                        m++;
                        d = 1;
                    end
                    else if (y < MAX_YEAR)
                    begin
                        y++;
                        m = MON_JAN;
                        d = 1;
                    end
                    else
                    begin
                        hit_edge = 1'b1;
                        break;
                    end
                end
                else
                begin
                    if (d > 1)
                    begin
                        d--;
                    end
                    else if (m > MON_JAN)
                    begin
                        m--;
                        d = days_in(y, m);
                    end
                    else if (y > 1)
                    begin
                        y--;
                        m = MON_DEC;
                        d = DAYS_LONG;
                    end
                    else
                    begin
                        hit_edge = 1'b1;
                        break;
                    end
                end
                steps--;
            end
            res.year      = 14'(y);
            res.month     = 4'(m);
            res.day       = 5'(d);
            res.range_err = hit_edge;
            return res;
        endfunction

        function void note_word(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                logic signed [15:0] offset);
            pending.push_back(walk_date(y, m, d, offset));
        endfunction

        function void check_word(date_t got);
            date_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result word with nothing pending: %0d-%0d-%0d err %0b",
                         $time, got.year, got.month, got.day, got.range_err);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.year !== want.year)
            begin
                $display("%0t: result_year expected %0d actual %0d",
                         $time, want.year, got.year);
                errors++;
            end
            if (got.month !== want.month)
            begin
                $display("%0t: result_month expected %0d actual %0d",
                         $time, want.month, got.month);
                errors++;
            end
            if (got.day !== want.day)
            begin
                $display("%0t: result_day expected %0d actual %0d",
                         $time, want.day, got.day);
                errors++;
            end
            if (got.range_err !== want.range_err)
            begin
                $display("%0t: range_error expected %0b actual %0b",
                         $time, want.range_err, got.range_err);
                errors++;
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [13:0]        start_year   = '0;
    logic [3:0]         start_month  = '0;
    logic [4:0]         start_day    = '0;
    logic signed [15:0] day_offset   = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [13:0]        result_year;
    logic [3:0]         result_month;
    logic [4:0]         result_day;
    logic               range_error;

    date_scoreboard sb = new();

    int unsigned words_in  = 0;
    int unsigned cycles    = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    rx_mode_e    rx_mode   = RX_FREE;
    int unsigned mode_left = 0;

    calendar_date_add_days_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_year   (start_year),
        .start_month  (start_month),
        .start_day    (start_day),
        .day_offset   (day_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .range_error  (range_error)
    );

    always #CLK_HALF clk = ~clk;

    // watchdog, a hung block ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL calendar_date_add_days_core");
            $finish;
        end
    end

    // offer one word and hold it until the block takes it
    // called at a rising edge, returns at the edge where the word was accepted
    task automatic send_word(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                             input logic signed [15:0] offset);
        in_valid    <= 1'b1;
        start_year  <= y;
        start_month <= m;
        start_day   <= d;
        day_offset  <= offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(y, m, d, offset);
        words_in++;
    endtask

    // sender goes quiet until every pending result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (!sb.drained())
            @(posedge clk);
    endtask

    // receiver: check the word taken at this edge, then pick the next stall value
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_word('{result_year, result_month, result_day, range_error});
        if (hold_left > 0)
        begin
            // long hold-off so the output register fills and the input backs up
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && words_in >= HOLD_AT_WORD)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= mode_left[2];
            endcase
        end
    end

    initial
    begin
        logic [13:0]        y;
        logic [3:0]         m;
        logic [4:0]         d;
        logic signed [15:0] offset;
        int unsigned        burst_left;
        int unsigned        gap;
        int unsigned        pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, back to back
        // leap day rules: plain leap, common year, century, 400-year
        send_word(14'd2024, MON_FEB, 5'd28, 16'sd1);
        send_word(14'd2023, MON_FEB, 5'd28, 16'sd1);
        send_word(14'd1900, MON_FEB, 5'd28, 16'sd1);
        send_word(14'd2000, MON_FEB, 5'd28, 16'sd1);
        // year rollover both ways and back into a leap day
        send_word(14'd2023, MON_DEC, 5'd31, 16'sd1);
        send_word(14'd2024, MON_JAN, 5'd1, -16'sd1);
        send_word(14'd2024, 4'd3, 5'd1, -16'sd1);
        send_word(14'd2100, 4'd3, 5'd1, -16'sd1);
        send_word(14'd9998, MON_DEC, 5'd31, 16'sd1);
        send_word(14'd2, MON_JAN, 5'd1, -16'sd1);
        // zero offset gives the start date back
        send_word(14'd2024, 4'd7, 5'd15, 16'sd0);
        // walks past either end of the year range clamp and flag
        send_word(14'd9999, MON_DEC, 5'd31, 16'sd1);
        send_word(14'd1, MON_JAN, 5'd1, -16'sd1);
        send_word(14'd9999, MON_DEC, 5'd25, 16'sh7FFF);
        send_word(14'd1, MON_JAN, 5'd5, 16'sh8000);
        // largest offsets that stay in range
        send_word(14'd5000, MON_JUN, 5'd15, 16'sh7FFF);
        send_word(14'd5000, MON_JUN, 5'd15, 16'sh8000);
        // out of range start fields are clamped before the walk
        send_word(14'd0, 4'd0, 5'd0, 16'sd0);
        send_word(14'h3FFF, 4'hF, 5'd31, 16'sd0);
        send_word(14'd2023, MON_FEB, 5'd31, 16'sd0);
        send_word(14'd2024, MON_APR, 5'd31, 16'sd1);
        send_word(14'd0, MON_JAN, 5'd1, -16'sd1);
        send_word(14'h3FFF, 4'd13, 5'd0, 16'sd1);

        wait_drained();

        // random words in bursts
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                // well-formed date, often on a leap corner or a month edge
                if ($urandom_range(0, 9) < 3)
                    y = 14'(SPECIAL_YEARS[$urandom_range(0, 13)]);
                else
                    y = 14'($urandom_range(1, MAX_YEAR));
                m = 4'($urandom_range(1, 12));
                case ($urandom_range(0, 4))
                    0:       d = 5'd1;
                    1:       d = 5'(date_scoreboard::days_in(y, m));
                    default: d = 5'($urandom_range(1, date_scoreboard::days_in(y, m)));
                endcase
            end
            else
            begin
                // raw field values, clamping paths
                y = 14'($urandom_range(0, 16383));
                m = 4'($urandom_range(0, 15));
                d = 5'($urandom_range(0, 31));
            end

            // mostly short walks, a few over the whole offset range
            pick = $urandom_range(0, 99);
            if ((i % 20) == 19)
                offset = 16'($urandom());
            else if (pick < 50)
                offset = 16'($urandom_range(0, 120) - 60);
            else if (pick < 80)
                offset = 16'($urandom_range(0, 2000) - 1000);
            else
                offset = 16'($urandom_range(0, 12000) - 6000);

            send_word(y, m, d, offset);

            if (i == DRAIN_AT)
            begin
                wait_drained();
            end
            else if (burst_left == 0)
            begin
                // some bursts run straight into the next one
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end

        in_valid <= 1'b0;
        while (!sb.drained())
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS calendar_date_add_days_core");
        else
            $display("FAIL calendar_date_add_days_core");
        $finish;
    end

endmodule
